// ===== hw/rtl/mipa_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer pair ALU package
// Shared widths, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package mipa_pkg;

  localparam int DataWidth = 32;
  localparam int CntWidth  = $clog2(DataWidth + 1);

  typedef logic [2:0] op_t;
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;
  localparam op_t OP_MOD = 3'd4;
  localparam op_t OP_POW = 3'd5;
  localparam op_t OP_GCD = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_GCD,
    ST_DONE
  } state_t;

  // Start and status between the sequencer and the shared bit-serial divider.
  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quot;
    logic [DataWidth-1:0] rem;
  } div_rsp_t;

  // Shift-add multiplier handshake; result is the product modulo 2^DataWidth.
  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] mcand;
    logic [DataWidth-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== hw/rtl/mipa_divider.sv =====
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mipa_divider
  import mipa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DataWidth-1:0] quot_r, quot_nxt;
  logic [DataWidth-1:0] rem_r, rem_nxt;
  logic [DataWidth-1:0] dvsr_r, dvsr_nxt;
  logic [CntWidth-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DataWidth:0]   trial;
  logic [DataWidth:0]   diff;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quot_r[DataWidth-1]};
    diff     = trial - {1'b0, dvsr_r};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      cnt_nxt  = CntWidth'(DataWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DataWidth]) begin
        rem_nxt  = diff[DataWidth-1:0];
        quot_nxt = {quot_r[DataWidth-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[DataWidth-1:0];
        quot_nxt = {quot_r[DataWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/mipa_multiplier.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add multiply, one multiplier bit per cycle, product kept modulo 2^N.
// ----------------------------------------------------------------------------
module mipa_multiplier
  import mipa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [DataWidth-1:0] acc_r, acc_nxt;
  logic [DataWidth-1:0] mcand_r, mcand_nxt;
  logic [DataWidth-1:0] mplier_r, mplier_nxt;
  logic [CntWidth-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      cnt_nxt    = CntWidth'(DataWidth);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[DataWidth-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[DataWidth-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== hw/rtl/multicycle_integer_pair_alu.sv =====
// ----------------------------------------------------------------------------
// Multicycle integer pair ALU
// Add, subtract, multiply, divide, remainder, power and gcd on signed words.
// ----------------------------------------------------------------------------
// Add and subtract are computed into the accumulator on accept, then registered into the result word.
// Multiply, divide and remainder run on the bit-serial shift-add multiplier
// and restoring divider (one bit per cycle).
// Power takes up to 2 multiplies per exponent bit; gcd one division per step.
// One word is in work at a time; reset clears the sequencer and output valid.
module multicycle_integer_pair_alu
  import mipa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_req_type,
  input  logic [DataWidth-1:0] in_operand_a,
  input  logic [DataWidth-1:0] in_operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DataWidth-1:0] out_result_value,
  output logic                 out_divide_by_zero
);

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [DataWidth-1:0] a_r, a_nxt;
  logic [DataWidth-1:0] b_r, b_nxt;
  logic [DataWidth-1:0] acc_r, acc_nxt;
  logic                 neg_q_r, neg_q_nxt;
  logic                 neg_r_r, neg_r_nxt;
  logic [DataWidth-1:0] res_r, res_nxt;
  logic                 dz_r, dz_nxt;
  logic                 odz_r, odz_nxt;
  logic                 ovalid_r, ovalid_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic [DataWidth-1:0] mag_a, mag_b, srem;

  function automatic logic [DataWidth-1:0] abs_w(input logic [DataWidth-1:0] v);
    abs_w = v[DataWidth-1] ? (~v + 1'b1) : v;
  endfunction

  mipa_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  mipa_multiplier u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  assign mag_a = abs_w(a_r);
  assign mag_b = abs_w(b_r);
  // Remainder takes the dividend's sign.
  assign srem  = neg_r_r ? (~drsp.rem + 1'b1) : drsp.rem;

  // A new word may enter while the previous result still waits in the output
  // register; the finished word then waits in ST_DONE until that register is free.
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    res_nxt    = res_r;
    dz_nxt     = dz_r;
    odz_nxt    = odz_r;
    ovalid_nxt = ovalid_r;
    dreq       = '{start: 1'b0, dividend: mag_a, divisor: mag_b};
    mreq       = '{start: 1'b0, mcand: a_r, mplier: b_r};
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_req_type;
          a_nxt     = in_operand_a;
          b_nxt     = in_operand_b;
          acc_nxt   = '0;
          neg_q_nxt = 1'b0;
          neg_r_nxt = 1'b0;
          dz_nxt    = 1'b0;
          unique case (in_req_type)
            OP_ADD: acc_nxt = in_operand_a + in_operand_b;
            OP_SUB: acc_nxt = in_operand_a - in_operand_b;
            default: acc_nxt = '0;
          endcase
          unique case (in_req_type)
            OP_ADD, OP_SUB: state_nxt = ST_DONE;
            OP_MUL: state_nxt = ST_MUL;
            OP_DIV, OP_MOD: begin
              neg_q_nxt = in_operand_a[DataWidth-1] ^ in_operand_b[DataWidth-1];
              neg_r_nxt = in_operand_a[DataWidth-1];
              if (in_operand_b == '0) begin
                dz_nxt    = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_DIV;
              end
            end
            OP_POW: begin
              acc_nxt = in_operand_b[DataWidth-1] ? '0 : DataWidth'(1);
              state_nxt = ST_POW_MUL;
            end
            OP_GCD: state_nxt = ST_GCD;
            default: state_nxt = ST_DONE;
          endcase
          // Units are launched below, in the same cycle as the word is accepted.
          if (in_req_type == OP_MUL) begin
            mreq = '{start: 1'b1, mcand: in_operand_a, mplier: in_operand_b};
          end
          if ((in_req_type == OP_DIV || in_req_type == OP_MOD) &&
              in_operand_b != '0) begin
            dreq = '{start: 1'b1, dividend: abs_w(in_operand_a),
                     divisor: abs_w(in_operand_b)};
          end
          if (in_req_type == OP_GCD && in_operand_b != '0) begin
            dreq = '{start: 1'b1, dividend: abs_w(in_operand_a),
                     divisor: abs_w(in_operand_b)};
            neg_r_nxt = in_operand_a[DataWidth-1];
          end
          if (in_req_type == OP_GCD && in_operand_b == '0) begin
            acc_nxt   = in_operand_a;
            state_nxt = ST_DONE;
          end
          if (in_req_type == OP_POW && !in_operand_b[DataWidth-1] &&
              in_operand_b != '0) begin
            // Multiply the accumulator (1) by the base; the product is kept if the low bit is set.
            mreq = '{start: 1'b1, mcand: DataWidth'(1), mplier: in_operand_a};
          end else if (in_req_type == OP_POW) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (mrsp.done) begin
          acc_nxt   = mrsp.prod;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          if (op_r == OP_DIV) begin
            acc_nxt = neg_q_r ? (~drsp.quot + 1'b1) : drsp.quot;
          end else begin
            acc_nxt = srem;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_POW_MUL: begin
        // b_r holds the remaining exponent, a_r the current square.
        if (mrsp.done) begin
          if (b_r[0]) begin
            acc_nxt = mrsp.prod;
          end
          b_nxt = {1'b0, b_r[DataWidth-1:1]};
          if (b_nxt == '0) begin
            state_nxt = ST_DONE;
          end else begin
            mreq = '{start: 1'b1, mcand: a_r, mplier: a_r};
            state_nxt = ST_POW_SQ;
          end
        end
      end
      ST_POW_SQ: begin
        if (mrsp.done) begin
          a_nxt = mrsp.prod;
          mreq  = '{start: 1'b1, mcand: acc_r, mplier: mrsp.prod};
          state_nxt = ST_POW_MUL;
        end
      end
      ST_GCD: begin
        // Each step replaces (a, b) with (b, a rem b).
        if (drsp.done) begin
          a_nxt = b_r;
          b_nxt = srem;
          if (srem == '0) begin
            acc_nxt   = b_r;
            state_nxt = ST_DONE;
          end else begin
            neg_r_nxt = b_r[DataWidth-1];
            dreq = '{start: 1'b1, dividend: mag_b, divisor: abs_w(srem)};
          end
        end
      end
      ST_DONE: begin
        if (!ovalid_nxt) begin
          res_nxt    = acc_r;
          odz_nxt    = dz_r;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    res_r   <= res_nxt;
    dz_r    <= dz_nxt;
    odz_r   <= odz_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_result_value   = res_r;
  assign out_divide_by_zero = odz_r;

endmodule

// ===== hw/rtl/mipa_checker.sv =====
// ----------------------------------------------------------------------------
// Integer pair ALU port checker
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module mipa_checker
  import mipa_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [2:0]           in_req_type,
  input logic [DataWidth-1:0] in_operand_b,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DataWidth-1:0] out_result_value,
  input logic                 out_divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
    $stable(out_divide_by_zero))
    else $error("result word changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == '0)
    else $error("divide by zero with nonzero result");

  a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == OP_ADD && !out_valid |=> ##1 out_valid)
    else $error("add result late");

  a_dz_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == OP_DIV || in_req_type == OP_MOD) &&
    in_operand_b == '0 && !out_valid |=> ##1 out_valid && out_divide_by_zero)
    else $error("divide by zero not flagged");

endmodule

bind multicycle_integer_pair_alu mipa_checker u_mipa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_req_type(in_req_type), .in_operand_b(in_operand_b),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_result_value(out_result_value), .out_divide_by_zero(out_divide_by_zero)
);
